### hw/rtl/spq_pkg.sv
// Package for the sorted priority queue: sizes, field widths, command and status codes.
// No dependencies; every other file of the block imports it.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W   = 32;
  localparam int PRIO_W = 8;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 5;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } spq_cmd_t;

endpackage

### hw/rtl/spq_ctrl.sv
// Controller of the sorted priority queue: input handshake, execute step, result valid.
// Depends on spq_pkg.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output spq_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic go;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign go         = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign cmd.load   = in_tvalid && in_tready;
  assign cmd.exec   = go;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/spq_dp.sv
// Datapath of the sorted priority queue: the row of slot cells, entry count and result register.
// Depends on spq_pkg.
module spq_dp
  import spq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  spq_cmd_t          cmd,
  input  logic              in_cmd,
  input  logic [ID_W-1:0]   in_id,
  input  logic [PRIO_W-1:0] in_prio,
  output logic [ST_W-1:0]   res_status,
  output logic [ID_W-1:0]   res_id,
  output logic [PRIO_W-1:0] res_prio,
  output logic [OCC_W-1:0]  res_occ
);

  logic              op_r;
  logic [ID_W-1:0]   id_r;
  logic [PRIO_W-1:0] prio_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic [ID_W-1:0]   slot_id_r   [QUEUE_DEPTH];
  logic [PRIO_W-1:0] slot_prio_r [QUEUE_DEPTH];
  logic [ID_W-1:0]   slot_id_nxt   [QUEUE_DEPTH];
  logic [PRIO_W-1:0] slot_prio_nxt [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] keep;
  logic full, empty, write_slots;

  logic [ST_W-1:0]   status_r, status_nxt;
  logic [ID_W-1:0]   rid_r, rid_nxt;
  logic [PRIO_W-1:0] rprio_r, rprio_nxt;
  logic [OCC_W-1:0]  occ_r;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      keep[i] = (CNT_W'(i) < count_r) && (slot_prio_r[i] >= prio_r);
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (op_r == CMD_DEQ) begin
        if (i == QUEUE_DEPTH - 1) begin
          slot_id_nxt[i]   = slot_id_r[i];
          slot_prio_nxt[i] = slot_prio_r[i];
        end else begin
          slot_id_nxt[i]   = slot_id_r[i+1];
          slot_prio_nxt[i] = slot_prio_r[i+1];
        end
      end else if (keep[i]) begin
        slot_id_nxt[i]   = slot_id_r[i];
        slot_prio_nxt[i] = slot_prio_r[i];
      end else if (i == 0) begin
        slot_id_nxt[i]   = id_r;
        slot_prio_nxt[i] = prio_r;
      end else if (keep[i-1]) begin
        slot_id_nxt[i]   = id_r;
        slot_prio_nxt[i] = prio_r;
      end else begin
        slot_id_nxt[i]   = slot_id_r[i-1];
        slot_prio_nxt[i] = slot_prio_r[i-1];
      end
    end
  end

  always_comb begin
    write_slots = 1'b0;
    count_nxt   = count_r;
    status_nxt  = ST_OK;
    rid_nxt     = '0;
    rprio_nxt   = '0;
    if (op_r == CMD_ENQ) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        write_slots = 1'b1;
        count_nxt   = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        write_slots = 1'b1;
        count_nxt   = count_r - CNT_W'(1);
        rid_nxt     = slot_id_r[0];
        rprio_nxt   = slot_prio_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_cmd;
      id_r   <= in_id;
      prio_r <= in_prio;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      rid_r    <= rid_nxt;
      rprio_r  <= rprio_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
    if (cmd.exec && write_slots) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        slot_id_r[i]   <= slot_id_nxt[i];
        slot_prio_r[i] <= slot_prio_nxt[i];
      end
    end
  end

  assign res_status = status_r;
  assign res_id     = rid_r;
  assign res_prio   = rprio_r;
  assign res_occ    = occ_r;

endmodule

### hw/rtl/sorted_priority_queue.sv
// Sorted priority queue of QUEUE_DEPTH entries, highest priority first, ties in arrival order.
// An item has an accept cycle and an execute cycle, in which every slot cell compares its
// priority with the new one in parallel and the whole row shifts or inserts at once. The next
// item is accepted in the cycle after that execute cycle even while the result still waits to
// be taken; the execute cycle of that item waits only until the previous result has left the
// result register. Each item gives exactly one result. Depends on spq_pkg, spq_ctrl, spq_dp.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // patient_id[31:0], priority_req[39:32]
  input  logic                   in_tuser,   // cmd[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_id[31:0], out_priority[39:32],
                                             // occupancy[44:40], zero[47:45]
  output logic [ST_W-1:0]        out_tuser   // status[1:0]
);

  spq_cmd_t          cmd;
  logic [ID_W-1:0]   res_id;
  logic [PRIO_W-1:0] res_prio;
  logic [OCC_W-1:0]  res_occ;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_cmd     (in_tuser),
    .in_id      (in_tdata[ID_W-1:0]),
    .in_prio    (in_tdata[ID_W+PRIO_W-1:ID_W]),
    .res_status (out_tuser),
    .res_id     (res_id),
    .res_prio   (res_prio),
    .res_occ    (res_occ)
  );

  assign out_tdata = {{(OUT_TDATA_W - ID_W - PRIO_W - OCC_W){1'b0}}, res_occ, res_prio, res_id};

endmodule

### hw/rtl/spq_chk.sv
// Port checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
module spq_chk
  import spq_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [ST_W-1:0]        out_tuser
);

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_EMPTY || out_tuser == ST_FULL))
    else $error("result status code out of range");

  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[ID_W+PRIO_W-1:0] == '0))
    else $error("failed item returned a nonzero entry");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[ID_W+PRIO_W+OCC_W-1:ID_W+PRIO_W] <= OCC_W'(QUEUE_DEPTH)))
    else $error("occupancy above queue depth");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is still executing");

endmodule

bind sorted_priority_queue spq_chk u_spq_chk (.*);
